>>> sv/frf_pkg.sv
// shared types, codes and default sizes for the framed receive queue
package frf_pkg;

    // width of one bus byte and of the configuration registers
    localparam int BYTE_W = 8;

    // default store sizes
    localparam int DEF_DATA_DEPTH  = 512;
    localparam int DEF_FRAME_DEPTH = 16;

    // request codes of one input item
    typedef enum logic [1:0] {
        REQ_BUS  = 2'd0,
        REQ_OPEN = 2'd1,
        REQ_POP  = 2'd2,
        REQ_NOP  = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic CFG_OWN_ID      = 1'b0;
    localparam logic CFG_FRAME_DELIM = 1'b1;

endpackage

>>> sv/framed_receive_fifo.sv
// framed receive queue: bus byte filter, byte store and frame length queue
//
// Command channel: an item (i_req_type, i_is_address, i_rx_byte) is taken at
// a rising edge with start high and busy low. busy stays low, so an item may
// be issued in every cycle. Each item gives exactly one result, shown on
// o_status, o_read_byte, o_bytes_left and o_frames_waiting for one cycle
// while o_done is high, the cycle after the item was taken. The receiver
// cannot hold results off, and none is needed: throughput 1 item
// per cycle. The rate follows from the single registered pass between the
// input and the result register; both stores are read one access ahead
// (with write bypass), so the head byte and head length are ready at once.
// Configuration: i_cfg_index selects own_id (0) or frame_delim (1); a
// transfer completes when i_cfg_valid and o_cfg_ready are high together.
// Write it only while the block is idle.
// Reset (i_rst_n low, synchronous) clears pointers, counts, filter phase and
// registers. The byte and length stores hold no reset value, so no clearing
// pass is needed and the block is ready in the first cycle after reset.
module framed_receive_fifo #(
    parameter int DATA_DEPTH  = frf_pkg::DEF_DATA_DEPTH,
    parameter int FRAME_DEPTH = frf_pkg::DEF_FRAME_DEPTH,
    localparam int CW = $clog2(DATA_DEPTH + 1),
    localparam int FW = $clog2(FRAME_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_req_type,
    input  logic                      i_is_address,
    input  logic [frf_pkg::BYTE_W-1:0] i_rx_byte,
    // result channel
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic [frf_pkg::BYTE_W-1:0] o_read_byte,
    output logic [CW-1:0]             o_bytes_left,
    output logic [FW-1:0]             o_frames_waiting,
    // configuration channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [frf_pkg::BYTE_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(DATA_DEPTH);
    localparam int FAW = $clog2(FRAME_DEPTH);
    localparam int SW  = CW + 1;
    localparam int BW  = frf_pkg::BYTE_W;

    localparam logic [AW-1:0]  DATA_LAST  = AW'(DATA_DEPTH - 1);
    localparam logic [FAW-1:0] FRAME_LAST = FAW'(FRAME_DEPTH - 1);
    localparam logic [CW-1:0]  DATA_FULL  = CW'(DATA_DEPTH);
    localparam logic [FW-1:0]  FRAME_FULL = FW'(FRAME_DEPTH);
    localparam logic [SW-1:0]  DATA_WRAP  = SW'(DATA_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ID,
        PH_DATA
    } t_rx_phase;

    // configuration registers
    logic [BW-1:0] r_own_id;
    logic [BW-1:0] r_frame_delim;

    // queue state
    t_rx_phase      r_rx_phase,       n_rx_phase;
    logic [AW-1:0]  r_write_ptr,      n_write_ptr;
    logic [AW-1:0]  r_read_ptr,       n_read_ptr;
    logic [CW-1:0]  r_bytes_stored,   n_bytes_stored;
    logic [CW-1:0]  r_open_bytes,     n_open_bytes;
    logic [FAW-1:0] r_len_write_ptr,  n_len_write_ptr;
    logic [FAW-1:0] r_len_read_ptr,   n_len_read_ptr;
    logic [FW-1:0]  r_frame_total,    n_frame_total;
    logic [CW-1:0]  r_read_remaining, n_read_remaining;

    // result registers
    logic                  r_done;
    frf_pkg::t_status      r_status,    n_status;
    logic [BW-1:0]         r_read_byte, n_read_byte;

    // stores and their read-ahead registers
    logic [BW-1:0] byte_mem [DATA_DEPTH];
    logic [CW-1:0] len_mem  [FRAME_DEPTH];
    logic [BW-1:0] r_byte_q;
    logic [CW-1:0] r_len_q;

    logic          w_accept;
    logic          w_byte_wr;
    logic          w_len_wr;
    logic [CW-1:0] w_discard;
    logic [SW-1:0] w_skip_sum;
    logic [AW-1:0] w_skip_ptr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // skip over unread bytes of the frame being read when the next one opens
    always_comb begin
        w_discard  = (r_read_remaining < r_bytes_stored) ? r_read_remaining : r_bytes_stored;
        w_skip_sum = SW'(r_read_ptr) + SW'(w_discard);
        if (w_skip_sum >= DATA_WRAP) begin
            w_skip_sum = w_skip_sum - DATA_WRAP;
        end
        w_skip_ptr = w_skip_sum[AW-1:0];
    end

    // next state for one item
    always_comb begin
        n_rx_phase       = r_rx_phase;
        n_write_ptr      = r_write_ptr;
        n_read_ptr       = r_read_ptr;
        n_bytes_stored   = r_bytes_stored;
        n_open_bytes     = r_open_bytes;
        n_len_write_ptr  = r_len_write_ptr;
        n_len_read_ptr   = r_len_read_ptr;
        n_frame_total    = r_frame_total;
        n_read_remaining = r_read_remaining;
        n_status         = frf_pkg::ST_OK;
        n_read_byte      = '0;
        w_byte_wr        = 1'b0;
        w_len_wr         = 1'b0;
        if (w_accept) begin
            unique case (frf_pkg::t_req'(i_req_type))
                frf_pkg::REQ_BUS: begin
                    if (i_is_address) begin
                        n_rx_phase = PH_ID;
                    end else begin
                        unique case (r_rx_phase)
                            PH_ID: begin
                                n_rx_phase = (i_rx_byte != r_own_id) ? PH_DATA : PH_IDLE;
                            end
                            PH_DATA: begin
                                if (i_rx_byte == r_frame_delim && r_open_bytes != '0) begin
                                    // closing delimiter: queue the frame length
                                    if (r_frame_total == FRAME_FULL) begin
                                        n_status = frf_pkg::ST_FULL;
                                    end else begin
                                        w_len_wr        = 1'b1;
                                        n_len_write_ptr = (r_len_write_ptr == FRAME_LAST) ?
                                                          '0 : r_len_write_ptr + FAW'(1);
                                        n_frame_total   = r_frame_total + FW'(1);
                                        n_open_bytes    = '0;
                                    end
                                end else if (r_bytes_stored == DATA_FULL) begin
                                    n_status = frf_pkg::ST_FULL;
                                end else begin
                                    w_byte_wr      = 1'b1;
                                    n_write_ptr    = (r_write_ptr == DATA_LAST) ?
                                                     '0 : r_write_ptr + AW'(1);
                                    n_bytes_stored = r_bytes_stored + CW'(1);
                                    n_open_bytes   = r_open_bytes + CW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                frf_pkg::REQ_OPEN: begin
                    if (r_frame_total == '0) begin
                        n_status = frf_pkg::ST_EMPTY;
                    end else begin
                        n_read_ptr       = w_skip_ptr;
                        n_bytes_stored   = r_bytes_stored - w_discard;
                        n_read_remaining = r_len_q;
                        n_len_read_ptr   = (r_len_read_ptr == FRAME_LAST) ?
                                           '0 : r_len_read_ptr + FAW'(1);
                        n_frame_total    = r_frame_total - FW'(1);
                    end
                end
                frf_pkg::REQ_POP: begin
                    if (r_read_remaining == '0 || r_bytes_stored == '0) begin
                        n_status = frf_pkg::ST_EMPTY;
                    end else begin
                        n_read_byte      = r_byte_q;
                        n_read_ptr       = (r_read_ptr == DATA_LAST) ? '0 : r_read_ptr + AW'(1);
                        n_bytes_stored   = r_bytes_stored - CW'(1);
                        n_read_remaining = r_read_remaining - CW'(1);
                    end
                end
                frf_pkg::REQ_NOP: ;
            endcase
        end
    end

    // state, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id         <= '0;
            r_frame_delim    <= '0;
            r_rx_phase       <= PH_IDLE;
            r_write_ptr      <= '0;
            r_read_ptr       <= '0;
            r_bytes_stored   <= '0;
            r_open_bytes     <= '0;
            r_len_write_ptr  <= '0;
            r_len_read_ptr   <= '0;
            r_frame_total    <= '0;
            r_read_remaining <= '0;
            r_done           <= 1'b0;
            r_status         <= frf_pkg::ST_OK;
            r_read_byte      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    frf_pkg::CFG_OWN_ID:      r_own_id      <= i_cfg_data;
                    frf_pkg::CFG_FRAME_DELIM: r_frame_delim <= i_cfg_data;
                endcase
            end
            r_rx_phase       <= n_rx_phase;
            r_write_ptr      <= n_write_ptr;
            r_read_ptr       <= n_read_ptr;
            r_bytes_stored   <= n_bytes_stored;
            r_open_bytes     <= n_open_bytes;
            r_len_write_ptr  <= n_len_write_ptr;
            r_len_read_ptr   <= n_len_read_ptr;
            r_frame_total    <= n_frame_total;
            r_read_remaining <= n_read_remaining;
            r_done           <= w_accept;
            r_status         <= n_status;
            r_read_byte      <= n_read_byte;
        end
    end

    // byte store, read one access ahead at the next read pointer
    always_ff @(posedge i_clk) begin
        if (w_byte_wr) begin
            byte_mem[r_write_ptr] <= i_rx_byte;
        end
        if (w_byte_wr && r_write_ptr == n_read_ptr) begin
            r_byte_q <= i_rx_byte;
        end else begin
            r_byte_q <= byte_mem[n_read_ptr];
        end
    end

    // length store, read one access ahead at the next head
    always_ff @(posedge i_clk) begin
        if (w_len_wr) begin
            len_mem[r_len_write_ptr] <= r_open_bytes;
        end
        if (w_len_wr && r_len_write_ptr == n_len_read_ptr) begin
            r_len_q <= r_open_bytes;
        end else begin
            r_len_q <= len_mem[n_len_read_ptr];
        end
    end

    // result ports
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_read_byte      = r_read_byte;
    assign o_bytes_left     = r_read_remaining;
    assign o_frames_waiting = r_frame_total;

    // checks
    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_stored <= DATA_FULL)
        else $error("byte count beyond store depth");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_total <= FRAME_FULL)
        else $error("frame count beyond queue depth");

    a_open_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_bytes <= r_bytes_stored)
        else $error("open frame holds more bytes than stored");

    a_len_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_total == '0 |-> r_len_read_ptr == r_len_write_ptr)
        else $error("length pointers differ with no frame queued");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted item gave no result");

endmodule

>>> tb/sv/tb_framed_receive_fifo.sv
// self-checking bench for the framed receive queue: directed table, then random traffic
module tb_framed_receive_fifo;
    import frf_pkg::*;

    localparam int DEPTH_B = DEF_DATA_DEPTH;
    localparam int DEPTH_F = DEF_FRAME_DEPTH;

    // filter phase of the bus receiver
    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_ID,
        PHASE_DATA
    } rx_phase_t;

    // one reply of the block
    typedef struct packed {
        t_status    st;
        logic [7:0] rd;
        logic [9:0] left;
        logic [4:0] waiting;
    } reply_t;

    // one row of the directed table
    typedef struct packed {
        t_req       rq;
        logic       adr;
        logic [7:0] byt;
        logic       typed;
        reply_t     want;
    } table_row_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_req_type;
    logic       i_is_address;
    logic [7:0] i_rx_byte;
    logic       o_done;
    logic [1:0] o_status;
    logic [7:0] o_read_byte;
    logic [9:0] o_bytes_left;
    logic [4:0] o_frames_waiting;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    // queue state as the block should hold it
    rx_phase_t  phase;
    logic [7:0] byte_mem [DEPTH_B];
    logic [8:0] wr_ptr;
    logic [8:0] rd_ptr;
    logic [9:0] stored_cnt;
    logic [9:0] open_cnt;
    logic [9:0] remaining;
    logic [9:0] len_mem [DEPTH_F];
    logic [3:0] len_wr;
    logic [3:0] len_rd;
    logic [4:0] frames_cnt;
    logic [7:0] own_id_cfg;
    logic [7:0] delim_cfg;

    reply_t     replies_due [$];
    table_row_t directed_rows [$];
    int         fault_count;
    int         accepted_items;
    bit         no_gaps;

    framed_receive_fifo i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_is_address     (i_is_address),
        .i_rx_byte        (i_rx_byte),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_read_byte      (o_read_byte),
        .o_bytes_left     (o_bytes_left),
        .o_frames_waiting (o_frames_waiting),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // advance the queue state by one request and give the reply it should cause
    function automatic reply_t step_frame_queue(t_req rq, logic adr, logic [7:0] byt);
        reply_t     r;
        logic [9:0] skip;
        r.st = ST_OK;
        r.rd = 8'h00;
        case (rq)
            REQ_BUS: begin
                if (adr) begin
                    phase = PHASE_ID;
                end else if (phase == PHASE_ID) begin
                    phase = (byt != own_id_cfg) ? PHASE_DATA : PHASE_IDLE;
                end else if (phase == PHASE_DATA) begin
                    if (byt == delim_cfg && open_cnt != 0) begin
                        // close the frame unless the length queue is full
                        if (frames_cnt >= DEPTH_F) begin
                            r.st = ST_FULL;
                        end else begin
                            len_mem[len_wr] = open_cnt;
                            len_wr          = len_wr + 1'b1;
                            frames_cnt      = frames_cnt + 1'b1;
                            open_cnt        = '0;
                        end
                    end else if (stored_cnt >= DEPTH_B) begin
                        r.st = ST_FULL;
                    end else begin
                        byte_mem[wr_ptr] = byt;
                        wr_ptr           = wr_ptr + 1'b1;
                        stored_cnt       = stored_cnt + 1'b1;
                        open_cnt         = open_cnt + 1'b1;
                    end
                end
            end
            REQ_OPEN: begin
                if (frames_cnt == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    // unread bytes of the frame in hand are thrown away first
                    skip       = (remaining < stored_cnt) ? remaining : stored_cnt;
                    rd_ptr     = rd_ptr + skip[8:0];
                    stored_cnt = stored_cnt - skip;
                    remaining  = len_mem[len_rd];
                    len_rd     = len_rd + 1'b1;
                    frames_cnt = frames_cnt - 1'b1;
                end
            end
            REQ_POP: begin
                if (remaining == 0 || stored_cnt == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    r.rd       = byte_mem[rd_ptr];
                    rd_ptr     = rd_ptr + 1'b1;
                    stored_cnt = stored_cnt - 1'b1;
                    remaining  = remaining - 1'b1;
                end
            end
            default: ;
        endcase
        r.left    = remaining;
        r.waiting = frames_cnt;
        return r;
    endfunction

    function automatic void add_row(t_req rq, logic adr, logic [7:0] byt, logic typed,
                                    t_status st, logic [7:0] rd, logic [9:0] left,
                                    logic [4:0] waiting);
        table_row_t row;
        row.rq           = rq;
        row.adr          = adr;
        row.byt          = byt;
        row.typed        = typed;
        row.want.st      = st;
        row.want.rd      = rd;
        row.want.left    = left;
        row.want.waiting = waiting;
        directed_rows.push_back(row);
    endfunction

    task automatic flag_failure(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", what);
    endtask

    // one request transfer, after a random gap; the reply is booked at the accepting edge
    task automatic send_item(input t_req rq, input logic adr, input logic [7:0] byt,
                             input logic typed, input reply_t want);
        int     gap;
        reply_t got;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= rq;
        i_is_address <= adr;
        i_rx_byte    <= byt;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // data bytes while the filter is idle are only ignored
        if (!(rq == REQ_BUS && !adr && phase == PHASE_IDLE))
            accepted_items++;
        got = step_frame_queue(rq, adr, byt);
        replies_due.push_back(typed ? want : got);
    endtask

    task automatic issue(input t_req rq, input logic adr, input logic [7:0] byt);
        send_item(rq, adr, byt, 1'b0, '0);
    endtask

    // stop requesting and let every booked reply come back
    task automatic settle();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        if (idx == CFG_OWN_ID)
            own_id_cfg = val;
        else
            delim_cfg = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one long frame that runs the byte store into overflow, then its delimiter
    task automatic fill_store();
        logic [7:0] b;
        issue(REQ_BUS, 1'b1, 8'($urandom_range(0, 255)));
        issue(REQ_BUS, 1'b0, own_id_cfg ^ 8'($urandom_range(1, 255)));
        while (stored_cnt < DEPTH_B) begin
            b = 8'($urandom_range(0, 255));
            if (b == delim_cfg)
                b = ~b;
            issue(REQ_BUS, 1'b0, b);
        end
        repeat (3) issue(REQ_BUS, 1'b0, ~delim_cfg);
        issue(REQ_BUS, 1'b0, delim_cfg);
    endtask

    // one burst of random traffic: noise, an addressed packet or a reader pass
    task automatic run_burst();
        int kind;
        int frames;
        int len;
        no_gaps = ($urandom_range(0, 3) == 0);
        kind    = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 8))
                issue(t_req'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        end else if (kind < 50) begin
            // address, id (sometimes our own, so the packet is filtered), short frames
            issue(REQ_BUS, 1'b1, 8'($urandom_range(0, 255)));
            issue(REQ_BUS, 1'b0, ($urandom_range(0, 5) == 0) ?
                  own_id_cfg : own_id_cfg ^ 8'($urandom_range(1, 255)));
            frames = $urandom_range(1, 6);
            for (int j = 0; j < frames; j++) begin
                len = $urandom_range(1, 8);
                repeat (len) issue(REQ_BUS, 1'b0, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) != 0)
                    issue(REQ_BUS, 1'b0, delim_cfg);
                if ($urandom_range(0, 9) == 0)
                    issue(REQ_POP, 1'b0, 8'h00);
            end
        end else begin
            // open frames and read part or all of each
            repeat ($urandom_range(1, 4)) begin
                issue(REQ_OPEN, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                len = $urandom_range(0, ((remaining < 12) ? remaining : 12) + 2);
                repeat (len)
                    issue(REQ_POP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // reply checker: every strobed reply against the oldest booked one
    always @(posedge i_clk) begin : check_replies
        reply_t due;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (replies_due.size() == 0) begin
                flag_failure("reply with no request outstanding");
            end else begin
                due = replies_due.pop_front();
                if (o_status !== due.st || o_read_byte !== due.rd ||
                    o_bytes_left !== due.left || o_frames_waiting !== due.waiting)
                    flag_failure($sformatf({"reply mismatch: expected st=%0d byte=%02h ",
                        "left=%0d waiting=%0d, got st=%0d byte=%02h left=%0d waiting=%0d"},
                        due.st, due.rd, due.left, due.waiting,
                        o_status, o_read_byte, o_bytes_left, o_frames_waiting));
            end
        end
    end

    // stimulus
    initial begin
        int target;
        fault_count    = 0;
        accepted_items = 0;
        no_gaps        = 1'b0;
        phase          = PHASE_IDLE;
        wr_ptr         = '0;
        rd_ptr         = '0;
        stored_cnt     = '0;
        open_cnt       = '0;
        remaining      = '0;
        len_wr         = '0;
        len_rd         = '0;
        frames_cnt     = '0;
        own_id_cfg     = '0;
        delim_cfg      = '0;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_req_type   <= REQ_NOP;
        i_is_address <= 1'b0;
        i_rx_byte    <= 8'h00;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_OWN_ID;
        i_cfg_data   <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_OWN_ID, 8'h5A);
        write_reg(CFG_FRAME_DELIM, 8'h7E);

        // empty queue, no-op, filter states, delimiter rules, reader edge cases
        add_row(REQ_OPEN, 1'b0, 8'h00, 1'b1, ST_EMPTY, 8'h00, 10'd0, 5'd0);
        add_row(REQ_POP,  1'b1, 8'hFF, 1'b1, ST_EMPTY, 8'h00, 10'd0, 5'd0);
        add_row(REQ_NOP,  1'b1, 8'hFF, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'hFF, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b1, 8'h00, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'h5A, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b1, 8'hFF, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'h00, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'h7E, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'hFF, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'h00, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'h7E, 1'b1, ST_OK,    8'h00, 10'd0, 5'd1);
        add_row(REQ_BUS,  1'b0, 8'h80, 1'b1, ST_OK,    8'h00, 10'd0, 5'd1);
        add_row(REQ_POP,  1'b0, 8'h00, 1'b1, ST_EMPTY, 8'h00, 10'd0, 5'd1);
        add_row(REQ_OPEN, 1'b0, 8'h00, 1'b1, ST_OK,    8'h00, 10'd3, 5'd0);
        add_row(REQ_POP,  1'b0, 8'h00, 1'b1, ST_OK,    8'h7E, 10'd2, 5'd0);
        add_row(REQ_POP,  1'b0, 8'h00, 1'b1, ST_OK,    8'hFF, 10'd1, 5'd0);
        add_row(REQ_POP,  1'b0, 8'h00, 1'b1, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_POP,  1'b0, 8'h00, 1'b1, ST_EMPTY, 8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'h7E, 1'b0, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'h01, 1'b0, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_BUS,  1'b0, 8'h7E, 1'b0, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_OPEN, 1'b0, 8'h00, 1'b0, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_OPEN, 1'b0, 8'h00, 1'b0, ST_OK,    8'h00, 10'd0, 5'd0);
        add_row(REQ_POP,  1'b0, 8'h00, 1'b0, ST_OK,    8'h00, 10'd0, 5'd0);

        no_gaps = ($urandom_range(0, 1) == 0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].rq, directed_rows[i].adr, directed_rows[i].byt,
                      directed_rows[i].typed, directed_rows[i].want);

        // random traffic under several register settings, extremes first
        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(CFG_OWN_ID, 8'h00);
                    write_reg(CFG_FRAME_DELIM, 8'hFF);
                end
                1: begin
                    write_reg(CFG_OWN_ID, 8'hFF);
                    write_reg(CFG_FRAME_DELIM, 8'h00);
                end
                default: begin
                    write_reg(CFG_OWN_ID, 8'($urandom_range(0, 255)));
                    write_reg(CFG_FRAME_DELIM, 8'($urandom_range(0, 255)));
                end
            endcase
            target = accepted_items + 250;
            if (p == 1)
                fill_store();
            while (accepted_items < target)
                run_burst();
        end

        settle();
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
sv/frf_pkg.sv
sv/framed_receive_fifo.sv
tb/sv/tb_framed_receive_fifo.sv
